/* hw/rtl/bsr_pkg.sv */
// Package for the banker's safety and request block.
// Field widths, command and status codes, lane control types and default sizes.
// No dependencies.
`default_nettype none
package bsr_pkg;

    localparam int DEF_NUM_PROCESSES = 8;
    localparam int DEF_NUM_RESOURCES = 4;
    localparam int DEF_AMOUNT_BITS   = 8;

    localparam int CMD_W       = 3;
    localparam int PROC_W      = 3;
    localparam int AMT_W       = 8;
    localparam int NUM_AMT     = 4;
    localparam int STATUS_W    = 2;
    localparam int ORD_W       = 3;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 8;
    localparam int WORK_XTRA   = 5;

    localparam logic [CMD_W-1:0] CMD_LOAD_MAX   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_ALLOC = 3'd1;
    localparam logic [CMD_W-1:0] CMD_LOAD_AVAIL = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CHECK      = 3'd3;
    localparam logic [CMD_W-1:0] CMD_REQUEST    = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EXCEED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_WAIT   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_UNSAFE = 2'd3;

    typedef enum logic [2:0] {
        LN_NONE,
        LN_LOAD_MAX,
        LN_LOAD_ALLOC,
        LN_LOAD_AVAIL,
        LN_GRANT,
        LN_ROLLBACK,
        LN_WORK_INIT,
        LN_WORK_ADD
    } t_lane_op;

    typedef struct packed {
        t_lane_op op;
    } t_lane_ctl;

    typedef struct packed {
        logic fits;
        logic exceed;
        logic lacks;
    } t_lane_stat;

endpackage
`default_nettype wire

/* hw/rtl/bankers_safety_and_request.sv */
// Banker's algorithm: one lane per resource, sequencer and result merge.
// A load writes its table in S_EXEC; a request is checked in S_REQ. The safety
// test scans one process per cycle in passes, at most NUM_PROCESSES passes,
// then gives one result per cycle while the output is not stalled. One item at
// a time; the next is taken in idle while the output register may still hold a
// result. Synchronous active-low reset clears the lane tables to zero.
// Depends on bsr_pkg and bsr_lane.
`default_nettype none
module bankers_safety_and_request
    import bsr_pkg::*;
#(
    parameter int NUM_PROCESSES = DEF_NUM_PROCESSES,
    parameter int NUM_RESOURCES = DEF_NUM_RESOURCES,
    parameter int AMOUNT_BITS   = DEF_AMOUNT_BITS
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // cmd[2:0], process[5:3], amount_0[13:6], amount_1[21:14],
    // amount_2[29:22], amount_3[37:30]
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // status[1:0], order_process[4:2]
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    output logic                        m_axis_tlast
);

    localparam int PW = (NUM_PROCESSES > 1) ? $clog2(NUM_PROCESSES) : 1;
    localparam int CW = $clog2(NUM_PROCESSES + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_EXEC, S_REQ, S_INIT, S_SCAN, S_UNSAFE, S_EMIT
    } t_state;

    t_state                 r_state, n_state;
    logic [CMD_W-1:0]       r_cmd;
    logic [PROC_W-1:0]      r_proc;
    logic [AMT_W-1:0]       r_amt [NUM_AMT];
    logic                   r_req_mode, n_req_mode;
    logic [PW-1:0]          r_scan, n_scan;
    logic [CW-1:0]          r_count, n_count;
    logic [PW-1:0]          r_emit, n_emit;
    logic [NUM_PROCESSES-1:0] r_done, n_done;
    logic                   r_progress, n_progress;
    logic [PW-1:0]          r_seq [NUM_PROCESSES];
    logic                   r_ov;
    logic [STATUS_W-1:0]    r_status, n_status;
    logic [ORD_W-1:0]       r_ord, n_ord;
    logic                   r_last, n_last;

    logic                   w_push, w_out_free, w_accept, w_proc_ok, w_fits_all, w_take;
    logic [STATUS_W-1:0]    w_req_status;
    t_lane_ctl              w_ctl;
    logic [PW-1:0]          w_idx;
    t_lane_stat             w_stat [NUM_RESOURCES];
    logic [NUM_RESOURCES-1:0] w_fits;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_ov || m_axis_tready;
    assign w_proc_ok     = (5'(r_proc) < 5'(NUM_PROCESSES));
    assign w_idx         = (r_state == S_SCAN) ? r_scan : PW'(r_proc);

    for (genvar g = 0; g < NUM_RESOURCES; g++) begin : g_lane
        logic [AMOUNT_BITS-1:0] w_amount;
        if (g < NUM_AMT) begin : g_fld
            assign w_amount = AMOUNT_BITS'(r_amt[g]);
        end else begin : g_zero
            assign w_amount = '0;
        end
        bsr_lane #(
            .NUM_PROCESSES(NUM_PROCESSES),
            .AMOUNT_BITS  (AMOUNT_BITS)
        ) u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_idx   (w_idx),
            .i_amount(w_amount),
            .o_stat  (w_stat[g])
        );
        assign w_fits[g] = w_stat[g].fits;
    end

    assign w_fits_all = &w_fits;
    assign w_take     = !r_done[r_scan] && w_fits_all;

    // lowest resource with a problem decides the status
    always_comb begin
        w_req_status = ST_OK;
        for (int r = NUM_RESOURCES - 1; r >= 0; r--) begin
            if (w_stat[r].exceed) begin
                w_req_status = ST_EXCEED;
            end else if (w_stat[r].lacks) begin
                w_req_status = ST_WAIT;
            end
        end
    end

    always_comb begin
        n_state    = r_state;
        n_req_mode = r_req_mode;
        n_scan     = r_scan;
        n_count    = r_count;
        n_emit     = r_emit;
        n_done     = r_done;
        n_progress = r_progress;
        n_status   = ST_OK;
        n_ord      = '0;
        n_last     = 1'b1;
        w_push     = 1'b0;
        w_ctl.op   = LN_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) n_state = S_EXEC;
            end
            S_EXEC: begin
                unique case (r_cmd) inside
                    CMD_LOAD_MAX, CMD_LOAD_ALLOC, CMD_LOAD_AVAIL: begin
                        if (w_out_free) begin
                            w_push  = 1'b1;
                            n_state = S_IDLE;
                            if (r_cmd == CMD_LOAD_AVAIL) begin
                                w_ctl.op = LN_LOAD_AVAIL;
                            end else if (w_proc_ok) begin
                                w_ctl.op = (r_cmd == CMD_LOAD_MAX) ? LN_LOAD_MAX
                                                                   : LN_LOAD_ALLOC;
                            end
                        end
                    end
                    CMD_CHECK: begin
                        n_req_mode = 1'b0;
                        n_state    = S_INIT;
                    end
                    CMD_REQUEST: begin
                        if (w_proc_ok) begin
                            n_state = S_REQ;
                        end else if (w_out_free) begin
                            w_push   = 1'b1;
                            n_status = ST_EXCEED;
                            n_state  = S_IDLE;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_REQ: begin
                if (w_req_status == ST_OK) begin
                    w_ctl.op   = LN_GRANT;
                    n_req_mode = 1'b1;
                    n_state    = S_INIT;
                end else if (w_out_free) begin
                    w_push   = 1'b1;
                    n_status = w_req_status;
                    n_state  = S_IDLE;
                end
            end
            S_INIT: begin
                w_ctl.op   = LN_WORK_INIT;
                n_scan     = '0;
                n_count    = '0;
                n_done     = '0;
                n_progress = 1'b0;
                n_state    = S_SCAN;
            end
            S_SCAN: begin
                if (w_take) begin
                    w_ctl.op       = LN_WORK_ADD;
                    n_done[r_scan] = 1'b1;
                    n_count        = r_count + 1'b1;
                    n_progress     = 1'b1;
                end
                if (r_scan == PW'(NUM_PROCESSES - 1)) begin
                    n_scan     = '0;
                    n_progress = 1'b0;
                    if (&n_done) begin
                        n_emit  = '0;
                        n_state = S_EMIT;
                    end else if (!(r_progress || w_take)) begin
                        n_state = S_UNSAFE;
                    end
                end else begin
                    n_scan = r_scan + 1'b1;
                end
            end
            S_UNSAFE: begin
                if (w_out_free) begin
                    w_push   = 1'b1;
                    n_status = ST_UNSAFE;
                    n_state  = S_IDLE;
                    if (r_req_mode) w_ctl.op = LN_ROLLBACK;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    w_push = 1'b1;
                    n_ord  = ORD_W'(r_seq[r_emit]);
                    n_last = (r_emit == PW'(NUM_PROCESSES - 1));
                    n_emit = r_emit + 1'b1;
                    if (n_last) n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_req_mode <= 1'b0;
            r_scan     <= '0;
            r_count    <= '0;
            r_emit     <= '0;
            r_done     <= '0;
            r_progress <= 1'b0;
            r_ov       <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_req_mode <= n_req_mode;
            r_scan     <= n_scan;
            r_count    <= n_count;
            r_emit     <= n_emit;
            r_done     <= n_done;
            r_progress <= n_progress;
            if (w_push) begin
                r_ov <= 1'b1;
            end else if (m_axis_tready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd  <= s_axis_tdata[CMD_W-1:0];
            r_proc <= s_axis_tdata[CMD_W +: PROC_W];
            for (int k = 0; k < NUM_AMT; k++) begin
                r_amt[k] <= s_axis_tdata[CMD_W + PROC_W + k*AMT_W +: AMT_W];
            end
        end
        if (r_state == S_SCAN && w_take) begin
            r_seq[r_count[PW-1:0]] <= r_scan;
        end
        if (w_push) begin
            r_status <= n_status;
            r_ord    <= n_ord;
            r_last   <= n_last;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = OUT_TDATA_W'({r_ord, r_status});
    assign m_axis_tlast  = r_last;

    a_count_matches_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN |-> $countones(r_done) == int'(r_count))
        else $error("finished count and done bits disagree");

    a_grant_from_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.op == LN_GRANT |-> r_state == S_REQ && w_req_status == ST_OK)
        else $error("grant outside request check");

    a_emit_ends_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EMIT && w_push && n_last |=> r_state == S_IDLE)
        else $error("sequence end did not return to idle");

    a_rollback_only_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.op == LN_ROLLBACK |-> r_req_mode && r_state == S_UNSAFE)
        else $error("rollback without a granted request");

endmodule
`default_nettype wire

/* hw/rtl/bsr_lane.sv */
// One resource lane: claim, allocation column, available count and work value.
// Uses bsr_pkg.
`default_nettype none
module bsr_lane
    import bsr_pkg::*;
#(
    parameter int NUM_PROCESSES = DEF_NUM_PROCESSES,
    parameter int AMOUNT_BITS   = DEF_AMOUNT_BITS,
    localparam int PW = (NUM_PROCESSES > 1) ? $clog2(NUM_PROCESSES) : 1,
    localparam int WW = AMOUNT_BITS + WORK_XTRA
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_lane_ctl              i_ctl,
    input  wire logic [PW-1:0]          i_idx,
    input  wire logic [AMOUNT_BITS-1:0] i_amount,
    output t_lane_stat                  o_stat
);

    logic [AMOUNT_BITS-1:0] r_max   [NUM_PROCESSES];
    logic [AMOUNT_BITS-1:0] r_alloc [NUM_PROCESSES];
    logic [AMOUNT_BITS-1:0] r_avail;
    logic [WW-1:0]          r_work;

    logic [AMOUNT_BITS-1:0] w_max, w_alloc;
    logic signed [AMOUNT_BITS:0] w_need;

    assign w_max   = r_max[i_idx];
    assign w_alloc = r_alloc[i_idx];
    assign w_need  = $signed({1'b0, w_max}) - $signed({1'b0, w_alloc});

    always_comb begin
        o_stat.fits   = $signed({{WORK_XTRA{w_need[AMOUNT_BITS]}}, w_need})
                        <= $signed({1'b0, r_work});
        o_stat.exceed = $signed({1'b0, i_amount}) > w_need;
        o_stat.lacks  = i_amount > r_avail;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < NUM_PROCESSES; p++) begin
                r_max[p]   <= '0;
                r_alloc[p] <= '0;
            end
            r_avail <= '0;
            r_work  <= '0;
        end else begin
            case (i_ctl.op)
                LN_LOAD_MAX:   r_max[i_idx] <= i_amount;
                LN_LOAD_ALLOC: r_alloc[i_idx] <= i_amount;
                LN_LOAD_AVAIL: r_avail <= i_amount;
                LN_GRANT: begin
                    r_avail        <= r_avail - i_amount;
                    r_alloc[i_idx] <= w_alloc + i_amount;
                end
                LN_ROLLBACK: begin
                    r_avail        <= r_avail + i_amount;
                    r_alloc[i_idx] <= w_alloc - i_amount;
                end
                LN_WORK_INIT: r_work <= WW'(r_avail);
                LN_WORK_ADD:  r_work <= r_work + WW'(w_alloc);
                default: ;
            endcase
        end
    end

endmodule
`default_nettype wire

/* tb/bsr_checker.sv */
// Checker for the banker's safety and request block: watches both streams,
// predicts the result items of each accepted command and compares them.
// Depends on bsr_pkg.
module bsr_checker
    import bsr_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   s_tvalid,
    input  wire logic                   s_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    input  wire logic                   m_tvalid,
    input  wire logic                   m_tready,
    input  wire logic [OUT_TDATA_W-1:0] m_tdata,
    input  wire logic                   m_tlast,
    output int                          o_fail_count,
    output int                          o_pending
);
    localparam int NP = 8;
    localparam int NR = 4;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ORD_W-1:0]    order;
        logic                last;
    } t_result;

    logic [AMT_W-1:0] claim_tbl [NP][NR];
    logic [AMT_W-1:0] alloc_tbl [NP][NR];
    logic [AMT_W-1:0] avail_vec [NR];
    t_result          result_q [$];
    int               mismatches;

    assign o_fail_count = mismatches;
    assign o_pending    = result_q.size();

    function automatic bit find_safe_order(output logic [ORD_W-1:0] seq [NP]);
        int  work [NR];
        bit  done [NP];
        int  count;
        bit  progress;
        bit  fits;
        int  need;
        for (int r = 0; r < NR; r++) work[r] = int'(avail_vec[r]);
        for (int p = 0; p < NP; p++) done[p] = 0;
        count = 0;
        while (count < NP) begin
            progress = 0;
            for (int p = 0; p < NP; p++) begin
                if (!done[p]) begin
                    fits = 1;
                    for (int r = 0; r < NR; r++) begin
                        need = int'(claim_tbl[p][r]) - int'(alloc_tbl[p][r]);
                        if (need > work[r]) fits = 0;
                    end
                    if (fits) begin
                        for (int r = 0; r < NR; r++) work[r] += int'(alloc_tbl[p][r]);
                        seq[count] = p[ORD_W-1:0];
                        count++;
                        done[p] = 1;
                        progress = 1;
                    end
                end
            end
            if (!progress) return 0;
        end
        return 1;
    endfunction

    task automatic push_single(input logic [STATUS_W-1:0] st);
        t_result e;
        e.status = st;
        e.order  = '0;
        e.last   = 1'b1;
        result_q.push_back(e);
    endtask

    task automatic push_order();
        logic [ORD_W-1:0] seq [NP];
        t_result e;
        if (find_safe_order(seq)) begin
            for (int i = 0; i < NP; i++) begin
                e.status = ST_OK;
                e.order  = seq[i];
                e.last   = (i == NP - 1);
                result_q.push_back(e);
            end
        end else begin
            push_single(ST_UNSAFE);
        end
    endtask

    task automatic predict(input logic [IN_TDATA_W-1:0] d);
        logic [CMD_W-1:0]  cmd;
        logic [PROC_W-1:0] pr;
        logic [AMT_W-1:0]  amt [NR];
        logic [STATUS_W-1:0] refusal;
        int                rem;
        logic [ORD_W-1:0]  seq [NP];
        cmd = d[2:0];
        pr  = d[5:3];
        for (int r = 0; r < NR; r++) amt[r] = d[6 + r*AMT_W +: AMT_W];
        case (cmd)
            CMD_LOAD_MAX: begin
                for (int r = 0; r < NR; r++) claim_tbl[pr][r] = amt[r];
                push_single(ST_OK);
            end
            CMD_LOAD_ALLOC: begin
                for (int r = 0; r < NR; r++) alloc_tbl[pr][r] = amt[r];
                push_single(ST_OK);
            end
            CMD_LOAD_AVAIL: begin
                for (int r = 0; r < NR; r++) avail_vec[r] = amt[r];
                push_single(ST_OK);
            end
            CMD_CHECK: push_order();
            CMD_REQUEST: begin
                refusal = ST_OK;
                for (int r = 0; r < NR; r++) begin
                    if (refusal == ST_OK) begin
                        rem = int'(claim_tbl[pr][r]) - int'(alloc_tbl[pr][r]);
                        if (int'(amt[r]) > rem) refusal = ST_EXCEED;
                        else if (amt[r] > avail_vec[r]) refusal = ST_WAIT;
                    end
                end
                if (refusal != ST_OK) begin
                    push_single(refusal);
                end else begin
                    for (int r = 0; r < NR; r++) begin
                        avail_vec[r] -= amt[r];
                        alloc_tbl[pr][r] += amt[r];
                    end
                    if (find_safe_order(seq)) begin
                        push_order();
                    end else begin
                        for (int r = 0; r < NR; r++) begin
                            avail_vec[r] += amt[r];
                            alloc_tbl[pr][r] -= amt[r];
                        end
                        push_single(ST_UNSAFE);
                    end
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        t_result e;
        if (!i_rst_n) begin
            for (int p = 0; p < NP; p++)
                for (int r = 0; r < NR; r++) begin
                    claim_tbl[p][r] = '0;
                    alloc_tbl[p][r] = '0;
                end
            for (int r = 0; r < NR; r++) avail_vec[r] = '0;
            result_q.delete();
            mismatches = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (result_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result item: status %0d order %0d last %0d",
                                 m_tdata[1:0], m_tdata[4:2], m_tlast);
                end else begin
                    e = result_q.pop_front();
                    if (m_tdata[1:0] !== e.status || m_tdata[4:2] !== e.order ||
                        m_tlast !== e.last || m_tdata[7:5] !== 3'b0) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp st %0d ord %0d last %0d, got %0d %0d %0d",
                                     e.status, e.order, e.last,
                                     m_tdata[1:0], m_tdata[4:2], m_tlast);
                    end
                end
            end
            if (s_tvalid && s_tready) predict(s_tdata);
        end
    end
endmodule

/* tb/tb.sv */
// Top of the banker's block testbench: clock, reset, command stimulus, output back-pressure and verdict.
// Depends on bsr_pkg, bankers_safety_and_request and bsr_checker.
module tb;
    import bsr_pkg::*;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;
    int                     fail_count;
    int                     pending;
    int                     idle_cycles;
    bit                     calm;
    bit                     hold_off;
    bit                     stim_done;
    logic [IN_TDATA_W-1:0]  cmd_q [$];

    bankers_safety_and_request DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_tvalid), .s_axis_tready(s_tready), .s_axis_tdata(s_tdata),
        .m_axis_tvalid(m_tvalid), .m_axis_tready(m_tready), .m_axis_tdata(m_tdata),
        .m_axis_tlast(m_tlast)
    );

    bsr_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial i_clk = 0;
    always begin
        #6 i_clk = 1;
        #6 i_clk = 0;
    end

    function automatic logic [IN_TDATA_W-1:0] pack_cmd(
        input logic [CMD_W-1:0] c, input logic [PROC_W-1:0] p,
        input logic [7:0] a0, input logic [7:0] a1,
        input logic [7:0] a2, input logic [7:0] a3);
        return {2'b00, a3, a2, a1, a0, p, c};
    endfunction

    function automatic logic [7:0] rnd_amt(input int hi);
        return 8'($urandom_range(hi, 0));
    endfunction

    task automatic add_rnd(input logic [CMD_W-1:0] c, input logic [PROC_W-1:0] p, input int hi);
        cmd_q.push_back(pack_cmd(c, p, rnd_amt(hi), rnd_amt(hi), rnd_amt(hi), rnd_amt(hi)));
    endtask

    // One random scenario: claims, allocations not bound to the claims, availability,
    // a check, then a mix of checks, requests, availability loads and invalid commands.
    task automatic add_scenario();
        int hi;
        hi = ($urandom_range(9, 0) == 0) ? 255 : 20;
        for (int p = 0; p < 8; p++) add_rnd(CMD_LOAD_MAX, PROC_W'(p), hi);
        for (int p = 0; p < 8; p++)
            add_rnd(CMD_LOAD_ALLOC, PROC_W'(p), ($urandom_range(4, 0) == 0) ? hi : hi / 3);
        add_rnd(CMD_LOAD_AVAIL, 3'd0, hi);
        add_rnd(CMD_CHECK, 3'd0, hi);
        for (int k = 0; k < 6; k++) begin
            case ($urandom_range(9, 0))
                0: add_rnd(CMD_CHECK, PROC_W'($urandom), hi);
                1: add_rnd(CMD_W'($urandom_range(7, 5)), PROC_W'($urandom), 255);
                2: add_rnd(CMD_LOAD_AVAIL, 3'd0, hi);
                default: add_rnd(CMD_REQUEST, PROC_W'($urandom),
                                 $urandom_range(1, 0) ? 4 : hi);
            endcase
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) m_tready <= 1'b0;
        else m_tready <= !hold_off && (calm || $urandom_range(99, 0) >= 37);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) idle_cycles <= 0;
        else if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        hold_off = 0;
        for (int n = 0; n < 6000; n++) begin
            @(posedge i_clk);
            if (n == 300) begin
                hold_off = 1;
                repeat (400) @(posedge i_clk);
                hold_off = 0;
            end
        end
    end

    initial begin
        calm = 0;
        stim_done = 0;
        i_rst_n = 0;
        s_tvalid = 0;
        s_tdata = '0;
        cmd_q.push_back(pack_cmd(CMD_CHECK, 0, 0, 0, 0, 0));
        cmd_q.push_back(pack_cmd(CMD_REQUEST, 0, 0, 0, 0, 0));
        cmd_q.push_back(pack_cmd(CMD_REQUEST, 0, 1, 0, 0, 0));
        cmd_q.push_back(pack_cmd(CMD_LOAD_MAX, 7, 255, 255, 255, 255));
        cmd_q.push_back(pack_cmd(CMD_LOAD_AVAIL, 0, 255, 255, 255, 255));
        cmd_q.push_back(pack_cmd(CMD_REQUEST, 7, 255, 255, 255, 255));
        cmd_q.push_back(pack_cmd(CMD_LOAD_ALLOC, 3, 255, 255, 255, 255));
        cmd_q.push_back(pack_cmd(CMD_CHECK, 0, 0, 0, 0, 0));
        cmd_q.push_back(pack_cmd(CMD_REQUEST, 3, 1, 0, 0, 0));
        cmd_q.push_back(pack_cmd(CMD_LOAD_AVAIL, 0, 0, 0, 0, 0));
        cmd_q.push_back(pack_cmd(CMD_LOAD_MAX, 1, 9, 9, 9, 9));
        cmd_q.push_back(pack_cmd(CMD_CHECK, 0, 0, 0, 0, 0));
        cmd_q.push_back(pack_cmd(CMD_LOAD_AVAIL, 0, 5, 5, 5, 5));
        cmd_q.push_back(pack_cmd(CMD_REQUEST, 1, 6, 0, 0, 0));
        cmd_q.push_back(pack_cmd(CMD_REQUEST, 1, 2, 2, 2, 2));
        cmd_q.push_back(pack_cmd(CMD_CHECK, 0, 0, 0, 0, 0));
        cmd_q.push_back(pack_cmd(3'd5, 2, 255, 255, 255, 255));
        cmd_q.push_back(pack_cmd(3'd7, 7, 0, 0, 0, 0));
        cmd_q.push_back(pack_cmd(CMD_LOAD_ALLOC, 3, 0, 0, 0, 0));
        cmd_q.push_back(pack_cmd(CMD_CHECK, 0, 0, 0, 0, 0));
        cmd_q.push_back(pack_cmd(CMD_REQUEST, 5, 1, 1, 1, 1));
        while (cmd_q.size() < 410) add_scenario();
        for (int i = 0; i < 20; i++) add_rnd(CMD_W'($urandom), PROC_W'($urandom), 255);
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        for (int i = 0; i < cmd_q.size(); i++) begin
            calm = (i >= 200 && i < 260);
            while (!calm && $urandom_range(99, 0) < 37) begin
                s_tvalid <= 0;
                @(posedge i_clk);
            end
            s_tvalid <= 1;
            s_tdata  <= cmd_q[i];
            @(posedge i_clk);
            while (!s_tready) @(posedge i_clk);
        end
        s_tvalid <= 0;
        stim_done = 1;
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
